// ===== rtl/core/format_spec_parser_unit_macros.svh =====
// Assertion macros of the format spec parser RTL, used by its top level.
`ifndef FORMAT_SPEC_PARSER_UNIT_MACROS_SVH
`define FORMAT_SPEC_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FSP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("format spec parser check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FSP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("format spec parser check failed");

`else

`define FSP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define FSP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/fsp_pkg.sv =====
// Types, character codes and helper functions of the format spec parser.
package fsp_pkg;

  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FLAGS = 3'd1,
    PH_WDIG  = 3'd2,
    PH_WDONE = 3'd3,
    PH_DOT   = 3'd4,
    PH_PDIG  = 3'd5,
    PH_PDONE = 3'd6,
    PH_LEN   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_VALID   = 2'd1,
    ST_INVALID = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_H    = 3'd1;
  localparam logic [2:0] LEN_HH   = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef struct packed {
    logic hash;
    logic space;
    logic plus;
    logic zero;
    logic left;
  } flags_t;

  typedef struct packed {
    logic        start_req;
    logic [7:0]  ch;
    logic [31:0] star_value;
  } fsp_item_t;

  typedef struct packed {
    status_t     status;
    flags_t      flags;
    logic [15:0] field_width;
    logic        prec_given;
    logic [15:0] prec_value;
    logic [2:0]  length_code;
    logic [7:0]  conversion;
  } fsp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_conv(input logic [7:0] c);
    return c inside {CH_D, CH_I, CH_U, CH_X, CH_XU, CH_O, CH_C, CH_S, CH_P, CH_N, CH_PCT};
  endfunction

endpackage

// ===== rtl/core/fsp_in_reg.sv =====
// Input register stage: captures one transaction and holds it until the engine takes it.
module fsp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  fsp_pkg::fsp_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output fsp_pkg::fsp_item_t item
);
  import fsp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  fsp_item_t item_r;

  // The stage refills in the same cycle that its content moves on.
  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// ===== rtl/core/fsp_engine.sv =====
// Spec state and the per-character decode that advances it.
module fsp_engine #(
  parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  fsp_pkg::fsp_item_t  item,
  output fsp_pkg::fsp_result_t result
);
  import fsp_pkg::*;

  localparam int ACC_W = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [31:0]           CNT_MAX32 = (32'd1 << COUNT_BITS) - 32'd1;

  phase_t                phase_r, phase_nxt;
  flags_t                flags_r, flags_nxt;
  logic [COUNT_BITS-1:0] width_r, width_nxt;
  logic [COUNT_BITS-1:0] prec_r, prec_nxt;
  logic                  prec_seen_r, prec_seen_nxt;
  logic [2:0]            len_r, len_nxt;

  logic                  handled;
  status_t               st;
  logic [7:0]            c;
  logic                  star_neg;
  logic [31:0]           star_mag;
  logic [COUNT_BITS-1:0] star_sat;
  logic [COUNT_BITS+15:0] width_ext;
  logic [COUNT_BITS+15:0] prec_ext;

  // acc * 10 + digit, clamped to the counter range; shift-add, no multiplier.
  function automatic logic [COUNT_BITS-1:0] acc_digit(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [7:0] ch);
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] v;
    ext = ACC_W'(acc);
    v   = (ext << 3) + (ext << 1) + ACC_W'(ch[3:0]);
    return (v > ACC_W'(CNT_MAX)) ? CNT_MAX : v[COUNT_BITS-1:0];
  endfunction

  assign c        = item.ch;
  assign star_neg = item.star_value[31];
  // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
  assign star_mag = star_neg ? (~item.star_value + 32'd1) : item.star_value;
  assign star_sat = (star_mag > CNT_MAX32) ? CNT_MAX : star_mag[COUNT_BITS-1:0];

  always_comb begin
    phase_nxt     = item.start_req ? PH_FLAGS : phase_r;
    flags_nxt     = item.start_req ? '0 : flags_r;
    width_nxt     = item.start_req ? '0 : width_r;
    prec_nxt      = item.start_req ? '0 : prec_r;
    prec_seen_nxt = item.start_req ? 1'b0 : prec_seen_r;
    len_nxt       = item.start_req ? LEN_NONE : len_r;
    handled       = 1'b0;
    st            = ST_BUSY;

    if (phase_nxt == PH_IDLE) begin
      st      = ST_NONE;
      handled = 1'b1;
    end

    // Each part of the spec either takes the character or hands it on.
    if (!handled && phase_nxt == PH_FLAGS) begin
      handled = 1'b1;
      case (c)
        CH_ZERO:  if (!flags_nxt.left) flags_nxt.zero = 1'b1;
        CH_SPACE: if (!flags_nxt.plus) flags_nxt.space = 1'b1;
        CH_HASH:  flags_nxt.hash = 1'b1;
        CH_MINUS: begin
          flags_nxt.left = 1'b1;
          flags_nxt.zero = 1'b0;
        end
        CH_PLUS: begin
          flags_nxt.plus  = 1'b1;
          flags_nxt.space = 1'b0;
        end
        CH_STAR: begin
          if (star_neg) begin
            flags_nxt.left = 1'b1;
            flags_nxt.zero = 1'b0;
          end
          width_nxt = star_sat;
          phase_nxt = PH_WDONE;
        end
        default: begin
          if (is_digit(c)) begin
            width_nxt = acc_digit(width_nxt, c);
            phase_nxt = PH_WDIG;
          end else begin
            handled   = 1'b0;
            phase_nxt = PH_WDONE;
          end
        end
      endcase
    end

    if (!handled && phase_nxt == PH_WDIG) begin
      if (is_digit(c)) begin
        width_nxt = acc_digit(width_nxt, c);
        handled   = 1'b1;
      end else begin
        phase_nxt = PH_WDONE;
      end
    end

    if (!handled && phase_nxt == PH_WDONE) begin
      if (c == CH_DOT) begin
        prec_seen_nxt = 1'b1;
        prec_nxt      = '0;
        phase_nxt     = PH_DOT;
        handled       = 1'b1;
      end else begin
        phase_nxt = PH_PDONE;
      end
    end

    if (!handled && phase_nxt == PH_DOT) begin
      if (c == CH_STAR) begin
        // A negative star precision counts as no precision at all.
        if (star_neg) begin
          prec_seen_nxt = 1'b0;
          prec_nxt      = '0;
        end else begin
          prec_nxt = star_sat;
        end
        phase_nxt = PH_PDONE;
        handled   = 1'b1;
      end else begin
        phase_nxt = PH_PDIG;
      end
    end

    if (!handled && phase_nxt == PH_PDIG) begin
      if (is_digit(c)) begin
        prec_nxt = acc_digit(prec_nxt, c);
        handled  = 1'b1;
      end else begin
        phase_nxt = PH_PDONE;
      end
    end

    if (!handled && phase_nxt == PH_PDONE) begin
      if (c == CH_H) begin
        len_nxt   = LEN_H;
        phase_nxt = PH_LEN;
        handled   = 1'b1;
      end else if (c == CH_L) begin
        len_nxt   = LEN_L;
        phase_nxt = PH_LEN;
        handled   = 1'b1;
      end
    end else if (!handled && phase_nxt == PH_LEN) begin
      if ((len_nxt == LEN_H && c == CH_H) || (len_nxt == LEN_L && c == CH_L)) begin
        len_nxt = len_nxt + 3'd1;
        handled = 1'b1;
      end
    end

    // Whatever no part took closes the spec.
    if (!handled) begin
      st        = is_conv(c) ? ST_VALID : ST_INVALID;
      phase_nxt = PH_IDLE;
    end
  end

  assign width_ext = {16'd0, width_nxt};
  assign prec_ext  = {16'd0, prec_nxt};

  always_comb begin
    if (st == ST_NONE) begin
      result        = '0;
      result.status = ST_NONE;
    end else begin
      result.status      = st;
      result.flags       = flags_nxt;
      result.field_width = width_ext[15:0];
      result.prec_given  = prec_seen_nxt;
      result.prec_value  = prec_ext[15:0];
      result.length_code = len_nxt;
      result.conversion  = (st == ST_BUSY) ? 8'd0 : c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      flags_r     <= '0;
      width_r     <= '0;
      prec_r      <= '0;
      prec_seen_r <= 1'b0;
      len_r       <= LEN_NONE;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      width_r     <= width_nxt;
      prec_r      <= prec_nxt;
      prec_seen_r <= prec_seen_nxt;
      len_r       <= len_nxt;
    end
  end
endmodule

// ===== rtl/core/format_spec_parser_unit.sv =====
// Top level of the printf conversion specification parser.
//
// The parser reads the characters that follow a percent sign, one per input
// transaction, and returns one result transaction for every input transaction.
// Input channel: in_tuser carries start_req, which opens a new spec and drops
// any spec still in progress; in_tdata carries the character and the integer
// argument that a star consumes. Result channel: out_tuser carries the status
// (in progress, complete valid, complete invalid, no spec open) and out_tdata
// carries the flags, width, precision, length code and conversion character
// gathered so far.
// An accepted input transaction waits in the input register until the decode
// moves it into the result register, from which its result is offered.
// Throughput is one transaction per cycle while the result side does not stall;
// the spec state is updated by one decode step per character, which sets that rate.
// A stall on the result side holds the result register; the input register
// still accepts one more transaction, after which in_tready falls until the
// result is taken. Reset closes any open spec and empties both registers.
`include "format_spec_parser_unit_macros.svh"

module format_spec_parser_unit #(
  parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] ch, [39:8] star_value
  input  logic        in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] left_adjust, [1] zero_pad, [2] plus_sign, [3] space_sign, [4] alt_form,
  // [20:5] field_width, [21] prec_given, [37:22] prec_value, [40:38] length_code,
  // [48:41] conversion, [55:49] zero fill
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] status
);
  import fsp_pkg::*;

  fsp_item_t   in_item;
  fsp_item_t   item;
  logic        item_valid;
  logic        take;
  logic        out_open;
  fsp_result_t result;
  fsp_result_t out_r;
  logic        out_valid_r;
  logic        out_valid_nxt;

  assign in_item.start_req  = in_tuser;
  assign in_item.ch         = in_tdata[7:0];
  assign in_item.star_value = in_tdata[39:8];

  // The result register can load when it is empty or being emptied this cycle.
  assign out_open = !out_valid_r || out_tready;
  assign take     = item_valid && out_open;

  fsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // The spec state advances exactly when a character moves into the result register.
  fsp_engine #(
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (take),
    .item    (item),
    .result  (result)
  );

  assign out_valid_nxt = take || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.conversion, out_r.length_code, out_r.prec_value,
                       out_r.prec_given, out_r.field_width, out_r.flags};

  // A result with no spec open carries nothing but its status.
  `FSP_ASSERT_NOW(a_none_is_blank, clk, rst_n, out_tvalid && out_r.status == ST_NONE, out_tdata == 56'd0)
  // Minus always wins over zero, plus always wins over space.
  `FSP_ASSERT_NOW(a_flag_priority, clk, rst_n, out_tvalid, !(out_r.flags.left && out_r.flags.zero) && !(out_r.flags.plus && out_r.flags.space))
  // The conversion character shows only on a closing result.
  `FSP_ASSERT_NOW(a_conv_on_close, clk, rst_n, out_tvalid && out_r.status == ST_BUSY, out_r.conversion == 8'd0)
  // A full input register behind a stalled result blocks new input.
  `FSP_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, item_valid && out_tvalid && !out_tready, !in_tready)
  // An accepted transaction is never dropped: the pipeline holds something next cycle.
  `FSP_ASSERT_NEXT(a_accept_kept, clk, rst_n, in_tvalid && in_tready, item_valid || out_tvalid)
endmodule
